/* design/evaporation_energy_sampler_defines.svh */
// Assertion macros used by the sampler controller.
// No dependencies.
`ifndef EVAPORATION_ENERGY_SAMPLER_DEFINES_SVH
`define EVAPORATION_ENERGY_SAMPLER_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define EES_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define EES_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

/* design/ees_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and command/status types for the evaporation sampler.
// No dependencies.
package ees_pkg;
    localparam int TABLE_DEPTH = 1024;
    localparam int WORD_BITS   = 32;
    localparam int CNT_BITS    = 11;

    localparam logic [1:0] OP_LOAD_E  = 2'd0;
    localparam logic [1:0] OP_LOAD_P  = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;

    localparam logic CFG_ENERGY = 1'b0;
    localparam logic CFG_PROB   = 1'b1;

    // Datapath step selected by the controller.
    localparam logic [3:0] CMD_NONE   = 4'd0;
    localparam logic [3:0] CMD_INIT   = 4'd1;
    localparam logic [3:0] CMD_RDEND  = 4'd2;
    localparam logic [3:0] CMD_CHKEND = 4'd3;
    localparam logic [3:0] CMD_RDMID  = 4'd4;
    localparam logic [3:0] CMD_CMPMID = 4'd5;
    localparam logic [3:0] CMD_RDBIN  = 4'd6;
    localparam logic [3:0] CMD_SETBIN = 4'd7;
    localparam logic [3:0] CMD_DIV    = 4'd8;
    localparam logic [3:0] CMD_MULD   = 4'd9;
    localparam logic [3:0] CMD_APPLY  = 4'd10;
    localparam logic [3:0] CMD_PROD   = 4'd11;
    localparam logic [3:0] CMD_FINAL  = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic       tsel;
        logic       rd_hi;
    } t_cmd;

    typedef struct packed {
        logic search_done;
        logic end_hit;
        logic bin_done;
        logic div_done;
    } t_status;
endpackage

/* design/ees_ram.sv */
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// No dependencies.
module ees_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read on one port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* design/ees_datapath.sv */
`timescale 1ns / 1ps
// Datapath: table memories, search indexes, divider, multipliers, output.
// Depends on ees_pkg and ees_ram.
module ees_datapath #(
    parameter int TABLE_DEPTH = ees_pkg::TABLE_DEPTH,
    parameter int WORD_BITS   = ees_pkg::WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ees_pkg::t_cmd        i_cmd,
    output ees_pkg::t_status     o_status,
    input  logic                 i_load,
    input  logic [1:0]           i_opcode,
    input  logic [9:0]           i_entry_index,
    input  logic [WORD_BITS-1:0] i_entry_grid,
    input  logic [WORD_BITS-1:0] i_entry_value,
    input  logic [WORD_BITS-1:0] i_incident_energy,
    input  logic [WORD_BITS-1:0] i_random_fraction,
    input  logic [ees_pkg::CNT_BITS-1:0] i_energy_points,
    input  logic [ees_pkg::CNT_BITS-1:0] i_prob_points,
    output logic [WORD_BITS-1:0] o_result,
    output logic                 o_over
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int FB = WORD_BITS / 2;
    localparam int DCW = $clog2(WORD_BITS + 1);
    localparam int PW = (AW > 10) ? AW + 1 : 11;

    logic [WORD_BITS-1:0] r_x0, r_x1, r_t;
    logic [AW-1:0] r_lo, r_hi, r_last;
    logic [WORD_BITS-1:0] r_glo, r_vlo;
    logic r_single;
    logic r_end_hit, r_bin_done;
    logic [WORD_BITS-1:0] r_den, r_frac, r_mag;
    logic [WORD_BITS:0] r_rem;
    logic r_neg;
    logic [DCW-1:0] r_dcnt;
    logic [2*WORD_BITS-1:0] r_prod;
    logic [WORD_BITS-1:0] r_outv;
    logic r_outo;

    logic [AW-1:0] addr, idx_mem, mid;
    logic we_e, we_p, idx_ok;
    logic [WORD_BITS-1:0] eg, ev, pg, pv, g, v, x;
    logic [PW-1:0] npt_w, ncl;

    assign x = i_cmd.tsel ? r_x1 : r_x0;
    assign g = i_cmd.tsel ? eg : pg;
    assign v = i_cmd.tsel ? ev : pv;
    assign mid = AW'((({1'b0, r_lo}) + ({1'b0, r_hi})) >> 1);
    assign idx_mem = AW'(i_entry_index);
    assign idx_ok = ({22'd0, i_entry_index} < 32'(TABLE_DEPTH));
    assign we_e = i_load && (i_opcode == ees_pkg::OP_LOAD_E) && idx_ok;
    assign we_p = i_load && (i_opcode == ees_pkg::OP_LOAD_P) && idx_ok;

    // Memory address: load index, then the step that reads.
    always_comb begin
        if (i_load) begin
            addr = idx_mem;
        end else begin
            unique case (i_cmd.op)
                ees_pkg::CMD_RDEND: addr = i_cmd.rd_hi ? r_last : '0;
                ees_pkg::CMD_RDMID: addr = mid;
                ees_pkg::CMD_RDBIN: addr = i_cmd.rd_hi ? r_hi : r_lo;
                default:            addr = r_lo;
            endcase
        end
    end

    ees_ram #(.WIDTH(WORD_BITS), .DEPTH(TABLE_DEPTH)) u_eg (.i_clk(i_clk), .i_we(we_e),
        .i_addr(addr), .i_wdata(i_entry_grid), .o_rdata(eg));
    ees_ram #(.WIDTH(WORD_BITS), .DEPTH(TABLE_DEPTH)) u_ev (.i_clk(i_clk), .i_we(we_e),
        .i_addr(addr), .i_wdata(i_entry_value), .o_rdata(ev));
    ees_ram #(.WIDTH(WORD_BITS), .DEPTH(TABLE_DEPTH)) u_pg (.i_clk(i_clk), .i_we(we_p),
        .i_addr(addr), .i_wdata(i_entry_grid), .o_rdata(pg));
    ees_ram #(.WIDTH(WORD_BITS), .DEPTH(TABLE_DEPTH)) u_pv (.i_clk(i_clk), .i_we(we_p),
        .i_addr(addr), .i_wdata(i_entry_value), .o_rdata(pv));

    // Clamped point count of the table under lookup.
    always_comb begin
        npt_w = i_cmd.tsel ? PW'(i_energy_points) : PW'(i_prob_points);
        if (npt_w == '0) begin
            ncl = PW'(1);
        end else if (npt_w > PW'(TABLE_DEPTH)) begin
            ncl = PW'(TABLE_DEPTH);
        end else begin
            ncl = npt_w;
        end
    end

    logic [WORD_BITS:0] rem_sh;
    assign rem_sh = {r_rem[WORD_BITS-1:0], 1'b0};

    // Sequenced datapath steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_hit  <= 1'b0;
            r_bin_done <= 1'b0;
            r_dcnt     <= '0;
        end else begin
            unique case (i_cmd.op)
                ees_pkg::CMD_INIT: begin
                    r_x0 <= i_random_fraction;
                    r_x1 <= i_incident_energy;
                end
                ees_pkg::CMD_RDEND: begin
                    r_lo     <= '0;
                    r_last   <= AW'(ncl - PW'(1));
                    r_hi     <= AW'(ncl - PW'(1));
                    r_single <= (ncl == PW'(1));
                end
                ees_pkg::CMD_CHKEND: begin
                    // rd_hi low: first entry on bus; high: last entry on bus.
                    if (!i_cmd.rd_hi) begin
                        r_glo <= g; r_vlo <= v;
                        r_end_hit <= r_single || (x <= g);
                    end else begin
                        r_vlo <= v;
                        r_end_hit <= (x >= g);
                    end
                end
                ees_pkg::CMD_CMPMID: begin
                    if (g <= x) r_lo <= mid; else r_hi <= mid;
                end
                ees_pkg::CMD_SETBIN: begin
                    if (!i_cmd.rd_hi) begin
                        r_glo <= g; r_vlo <= v;
                    end else begin
                        r_bin_done <= 1'b0;
                        r_dcnt <= DCW'(WORD_BITS);
                        r_rem <= {1'b0, x - r_glo};
                        r_den <= g - r_glo;
                        r_neg <= (v < r_vlo);
                        r_mag <= (v >= r_vlo) ? v - r_vlo : r_vlo - v;
                        r_frac <= '0;
                        if (g <= r_glo || x <= r_glo) begin
                            r_bin_done <= 1'b1;
                        end else if (x >= g) begin
                            r_vlo <= v;
                            r_bin_done <= 1'b1;
                        end
                    end
                end
                ees_pkg::CMD_DIV: begin
                    // One restoring division bit per cycle.
                    if (rem_sh >= {1'b0, r_den}) begin
                        r_rem  <= rem_sh - {1'b0, r_den};
                        r_frac <= {r_frac[WORD_BITS-2:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_frac <= {r_frac[WORD_BITS-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - DCW'(1);
                end
                ees_pkg::CMD_MULD: r_prod <= (2*WORD_BITS)'(r_mag) * (2*WORD_BITS)'(r_frac);
                ees_pkg::CMD_APPLY: begin
                    r_vlo <= r_neg ? r_vlo - r_prod[2*WORD_BITS-1:WORD_BITS]
                                   : r_vlo + r_prod[2*WORD_BITS-1:WORD_BITS];
                end
                ees_pkg::CMD_PROD: begin
                    // The X result is parked in r_t until T is known.
                    if (!i_cmd.tsel) r_t <= r_vlo;
                    else r_prod <= (2*WORD_BITS)'(r_t) * (2*WORD_BITS)'(r_vlo);
                end
                ees_pkg::CMD_FINAL: begin
                    r_outo <= (r_prod[2*WORD_BITS-1:WORD_BITS+FB] != '0);
                    r_outv <= (r_prod[2*WORD_BITS-1:WORD_BITS+FB] != '0) ? '1
                              : r_prod[WORD_BITS+FB-1:FB];
                end
                default: ;
            endcase
        end
    end

    assign o_status.search_done = (AW'(r_hi - r_lo) <= AW'(1));
    assign o_status.end_hit = r_end_hit;
    assign o_status.bin_done = r_bin_done;
    assign o_status.div_done = (r_dcnt == '0);
    assign o_result = r_outv;
    assign o_over = r_outo;
endmodule

/* design/ees_ctrl.sv */
`timescale 1ns / 1ps
// Controller sequencing both table lookups and the output handshake.
// Depends on ees_pkg and the assertion macro header.
`include "evaporation_energy_sampler_defines.svh"
module ees_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_opcode,
    output logic             o_stall,
    output logic             o_load,
    output ees_pkg::t_cmd    o_cmd,
    input  ees_pkg::t_status i_status,
    output logic             o_valid,
    input  logic             i_stall
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD0 = 4'd1, S_CK0 = 4'd2, S_RDN = 4'd3,
        S_CKN = 4'd4, S_RDM = 4'd5, S_CMPM = 4'd6, S_RDL = 4'd7, S_RDH = 4'd8,
        S_SETH = 4'd9, S_DIV = 4'd10, S_MUL = 4'd11, S_APP = 4'd12, S_PROD = 4'd13,
        S_FIN = 4'd14, S_OUT = 4'd15;

    logic [3:0] r_state, n_state;
    logic r_tsel, n_tsel;
    logic acc;

    assign o_stall = (r_state != S_IDLE);
    assign acc = i_valid && !o_stall;
    assign o_load = acc && (i_opcode != ees_pkg::OP_SAMPLE);
    assign o_valid = (r_state == S_OUT);

    // Next state and command.
    always_comb begin
        n_state = r_state;
        n_tsel = r_tsel;
        o_cmd.op = ees_pkg::CMD_NONE;
        o_cmd.tsel = r_tsel;
        o_cmd.rd_hi = 1'b0;
        unique case (r_state)
            S_IDLE: if (acc && i_opcode == ees_pkg::OP_SAMPLE) begin
                o_cmd.op = ees_pkg::CMD_INIT;
                n_tsel = 1'b0;
                n_state = S_RD0;
            end
            S_RD0: begin o_cmd.op = ees_pkg::CMD_RDEND; n_state = S_CK0; end
            S_CK0: begin o_cmd.op = ees_pkg::CMD_CHKEND; n_state = S_RDN; end
            S_RDN: begin
                o_cmd.op = ees_pkg::CMD_RDEND; o_cmd.rd_hi = 1'b1;
                n_state = i_status.end_hit ? S_PROD : S_CKN;
            end
            S_CKN: begin
                o_cmd.op = ees_pkg::CMD_CHKEND; o_cmd.rd_hi = 1'b1; n_state = S_RDM;
            end
            S_RDM: begin
                if (i_status.end_hit) n_state = S_PROD;
                else if (i_status.search_done) n_state = S_RDL;
                else begin o_cmd.op = ees_pkg::CMD_RDMID; n_state = S_CMPM; end
            end
            S_CMPM: begin o_cmd.op = ees_pkg::CMD_CMPMID; n_state = S_RDM; end
            S_RDL: begin o_cmd.op = ees_pkg::CMD_RDBIN; n_state = S_RDH; end
            S_RDH: begin
                o_cmd.op = ees_pkg::CMD_SETBIN;
                n_state = S_SETH;
            end
            S_SETH: begin
                // Issue the read of the upper bin entry here, consume next cycle.
                o_cmd.op = ees_pkg::CMD_RDBIN; o_cmd.rd_hi = 1'b1; n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = ees_pkg::CMD_SETBIN; o_cmd.rd_hi = 1'b1; n_state = S_MUL;
            end
            S_MUL: begin
                if (i_status.bin_done) n_state = S_PROD;
                else if (!i_status.div_done) o_cmd.op = ees_pkg::CMD_DIV;
                else begin o_cmd.op = ees_pkg::CMD_MULD; n_state = S_APP; end
            end
            S_APP: begin o_cmd.op = ees_pkg::CMD_APPLY; n_state = S_PROD; end
            S_PROD: begin
                o_cmd.op = ees_pkg::CMD_PROD;
                if (!r_tsel) begin n_tsel = 1'b1; n_state = S_RD0; end
                else n_state = S_FIN;
            end
            S_FIN: begin o_cmd.op = ees_pkg::CMD_FINAL; n_state = S_OUT; end
            S_OUT: if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tsel <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tsel <= n_tsel;
        end
    end

    `EES_ASSERT_IMP(a_no_accept_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `EES_ASSERT_NXT(a_out_holds, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `EES_ASSERT_NXT(a_fin_to_out, i_clk, i_rst_n, r_state == S_FIN, o_valid)
endmodule

/* design/evaporation_energy_sampler.sv */
`timescale 1ns / 1ps
// Top level of the evaporation energy sampler: config registers, controller, datapath.
// Depends on ees_pkg, ees_ctrl, ees_datapath and ees_ram.
// A sample takes two table lookups, probability then temperature, each a binary
// search of about log2(points) probes through the table RAM read port, then a
// one-bit-per-cycle WORD_BITS-step interpolation divider; a lookup that clamps to
// an end skips the search and the divider, and a load item leaves the controller
// idle. One item is in work at a time; the result is held until taken. Table RAMs
// need no clearing; unwritten entries are undefined.
module evaporation_energy_sampler #(
    parameter int TABLE_DEPTH = ees_pkg::TABLE_DEPTH,
    parameter int WORD_BITS   = ees_pkg::WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_opcode,
    input  logic [9:0]           i_entry_index,
    input  logic [WORD_BITS-1:0] i_entry_grid,
    input  logic [WORD_BITS-1:0] i_entry_value,
    input  logic [WORD_BITS-1:0] i_incident_energy,
    input  logic [WORD_BITS-1:0] i_random_fraction,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [ees_pkg::CNT_BITS-1:0] i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_BITS-1:0] o_sampled_energy,
    output logic                 o_saturated
);
    logic [ees_pkg::CNT_BITS-1:0] r_energy_points, r_prob_points;
    ees_pkg::t_cmd cmd;
    ees_pkg::t_status status;
    logic load;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy_points <= ees_pkg::CNT_BITS'(1);
            r_prob_points <= ees_pkg::CNT_BITS'(1);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == ees_pkg::CFG_ENERGY) r_energy_points <= i_cfg_data;
            else r_prob_points <= i_cfg_data;
        end
    end

    ees_ctrl u_ctrl (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_opcode(i_opcode), .o_stall(o_stall), .o_load(load), .o_cmd(cmd),
        .i_status(status), .o_valid(o_valid), .i_stall(i_stall));

    ees_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .WORD_BITS(WORD_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_load(load), .i_opcode(i_opcode), .i_entry_index(i_entry_index),
        .i_entry_grid(i_entry_grid), .i_entry_value(i_entry_value),
        .i_incident_energy(i_incident_energy), .i_random_fraction(i_random_fraction),
        .i_energy_points(r_energy_points), .i_prob_points(r_prob_points),
        .o_result(o_sampled_energy), .o_over(o_saturated));
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for evaporation_energy_sampler: table loads, lookups and product.
// Depends on ees_pkg and the sampler RTL; holds its own predictor of the lookups.
module tb;
    localparam logic [1:0] OP_IGNORED = 2'd3;
    localparam int         DEPTH      = 1024;

    typedef struct packed {
        logic [1:0]  op;
        logic [9:0]  idx;
        logic [31:0] grid;
        logic [31:0] val;
        logic [31:0] energy;
        logic [31:0] fraction;
    } t_sampler_req;

    typedef struct packed {
        logic [31:0] energy;
        logic        sat;
    } t_energy_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode = '0;
    logic [9:0]  i_entry_index = '0;
    logic [31:0] i_entry_grid = '0;
    logic [31:0] i_entry_value = '0;
    logic [31:0] i_incident_energy = '0;
    logic [31:0] i_random_fraction = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [ees_pkg::CNT_BITS-1:0] i_cfg_data = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_sampled_energy;
    logic        o_saturated;

    evaporation_energy_sampler uut (.*);

    always #6 i_clk = ~i_clk;

    // Predictor tables, updated when a request is accepted.
    logic [31:0] e_grid [DEPTH];
    logic [31:0] e_temp [DEPTH];
    logic [31:0] p_grid [DEPTH];
    logic [31:0] p_val  [DEPTH];
    logic [10:0] energy_count = 11'd1;
    logic [10:0] prob_count = 11'd1;

    // Generator-side copy of the grids, used to aim sample points at bins.
    logic [31:0] gen_e_grid [DEPTH];
    logic [31:0] gen_p_grid [DEPTH];
    int          e_loaded = 0;
    int          p_loaded = 0;

    t_sampler_req   pending_reqs[$];
    t_energy_result expected_energies[$];
    int  errors = 0;
    int  reqs_queued = 0;
    int  reqs_taken = 0;
    int  results_seen = 0;
    int  sat_seen = 0;
    bit  in_fire = 1'b0;
    bit  out_fire = 1'b0;
    int  send_gap = 0;
    int  hold_cycles = 0;
    bit  quiet_send = 1'b0;
    bit  quiet_recv = 1'b0;

    function automatic logic [31:0] tab_grid(input bit sel, input int i);
        return sel ? p_grid[i] : e_grid[i];
    endfunction

    function automatic logic [31:0] tab_val(input bit sel, input int i);
        return sel ? p_val[i] : e_temp[i];
    endfunction

    // Binary search and linear interpolation with clamping at both ends.
    function automatic logic [31:0] interp_lookup(input bit sel, input logic [10:0] cnt,
                                                  input logic [31:0] x);
        int n, lo, hi, mid;
        logic [63:0] glo, ghi, vlo, vhi, frac, mag, delta;
        n = (cnt == 0) ? 1 : ((cnt > DEPTH) ? DEPTH : int'(cnt));
        if (n == 1 || x <= tab_grid(sel, 0)) return tab_val(sel, 0);
        if (x >= tab_grid(sel, n - 1)) return tab_val(sel, n - 1);
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (tab_grid(sel, mid) <= x) lo = mid; else hi = mid;
        end
        glo = tab_grid(sel, lo);
        ghi = tab_grid(sel, hi);
        vlo = tab_val(sel, lo);
        vhi = tab_val(sel, hi);
        if (ghi <= glo || x <= glo) return vlo[31:0];
        if (x >= ghi) return vhi[31:0];
        frac = ((64'(x) - glo) << 32) / (ghi - glo);
        mag = (vhi >= vlo) ? vhi - vlo : vlo - vhi;
        delta = (mag * frac) >> 32;
        return (vhi >= vlo) ? 32'(vlo + delta) : 32'(vlo - delta);
    endfunction

    // Predict on acceptance and track the configuration.
    always @(posedge i_clk) begin
        logic [31:0] t, xv;
        logic [63:0] prod;
        t_energy_result exp_r;
        in_fire <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == ees_pkg::CFG_ENERGY) energy_count = i_cfg_data;
            else prob_count = i_cfg_data;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            reqs_taken++;
            case (i_opcode)
                ees_pkg::OP_LOAD_E: begin
                    e_grid[i_entry_index] = i_entry_grid;
                    e_temp[i_entry_index] = i_entry_value;
                end
                ees_pkg::OP_LOAD_P: begin
                    p_grid[i_entry_index] = i_entry_grid;
                    p_val[i_entry_index] = i_entry_value;
                end
                ees_pkg::OP_SAMPLE: begin
                    xv = interp_lookup(1'b1, prob_count, i_random_fraction);
                    t = interp_lookup(1'b0, energy_count, i_incident_energy);
                    prod = (64'(t) * 64'(xv)) >> 16;
                    exp_r.sat = (prod > 64'hFFFF_FFFF);
                    exp_r.energy = exp_r.sat ? 32'hFFFF_FFFF : prod[31:0];
                    expected_energies.push_back(exp_r);
                end
                default: ;
            endcase
        end
    end

    // Compare each taken result with the oldest expectation.
    always @(posedge i_clk) begin
        t_energy_result exp_r;
        out_fire <= i_rst_n && o_valid && !i_stall;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_energies.size() == 0) begin
                $error("unexpected result: sampled_energy %h saturated %b",
                       o_sampled_energy, o_saturated);
                errors++;
            end else begin
                exp_r = expected_energies.pop_front();
                if (exp_r.sat) sat_seen++;
                if (o_sampled_energy !== exp_r.energy) begin
                    $error("sampled_energy: expected %h actual %h",
                           exp_r.energy, o_sampled_energy);
                    errors++;
                end
                if (o_saturated !== exp_r.sat) begin
                    $error("saturated: expected %b actual %b", exp_r.sat, o_saturated);
                    errors++;
                end
            end
        end
    end

    // Request driver: holds a stalled request, otherwise waits its gap and sends the next.
    always @(negedge i_clk) begin
        t_sampler_req r;
        if (i_rst_n) begin
            if (i_valid && !in_fire) begin
                // Request still waiting; payload stays put.
            end else if (send_gap > 0) begin
                i_valid = 1'b0;
                send_gap--;
            end else if (pending_reqs.size() > 0) begin
                r = pending_reqs.pop_front();
                i_opcode = r.op;
                i_entry_index = r.idx;
                i_entry_grid = r.grid;
                i_entry_value = r.val;
                i_incident_energy = r.energy;
                i_random_fraction = r.fraction;
                i_valid = 1'b1;
                if ($urandom_range(0, 40) == 0) quiet_send = ~quiet_send;
                send_gap = quiet_send ? 0 : $urandom_range(0, 16);
            end else begin
                i_valid = 1'b0;
            end
        end
    end

    // Result receiver: draws a stall length for every result it takes.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                if ($urandom_range(0, 30) == 0) quiet_recv = ~quiet_recv;
                hold_cycles = quiet_recv ? 0 : $urandom_range(0, 16);
            end
            if (hold_cycles > 0) begin
                i_stall = 1'b1;
                hold_cycles--;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    task automatic queue_req(input logic [1:0] op, input logic [9:0] idx,
                             input logic [31:0] g, input logic [31:0] v,
                             input logic [31:0] en, input logic [31:0] fr);
        t_sampler_req r;
        r = '{op: op, idx: idx, grid: g, val: v, energy: en, fraction: fr};
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    // Value with a random magnitude so that products both fit and saturate.
    function automatic logic [31:0] rand_value();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // Load entries 0..n-1 of one table; shape 0 ascending, 1 random, 2 with repeats.
    task automatic load_table(input bit sel, input int n, input int shape);
        logic [63:0] step, g;
        int i;
        step = (64'd1 << 32) / n;
        for (i = 0; i < n; i++) begin
            if (shape == 1) g = 64'($urandom);
            else if (shape == 2 && i > 0 && $urandom_range(0, 3) == 0)
                g = 64'(sel ? gen_p_grid[i - 1] : gen_e_grid[i - 1]);
            else g = 64'(i) * step + ((step > 1) ? $urandom_range(0, 32'(step - 1)) : 0);
            if (sel) gen_p_grid[i] = g[31:0]; else gen_e_grid[i] = g[31:0];
            queue_req(sel ? ees_pkg::OP_LOAD_P : ees_pkg::OP_LOAD_E, 10'(i), g[31:0],
                      rand_value(), $urandom, $urandom);
        end
        if (sel) p_loaded = (n > p_loaded) ? n : p_loaded;
        else e_loaded = (n > e_loaded) ? n : e_loaded;
    endtask

    // Sample point aimed at the table: ends, exact grid points, inside bins, anywhere.
    function automatic logic [31:0] aim_point(input bit sel, input int n);
        int k;
        logic [31:0] a, b;
        k = $urandom_range(0, n - 1);
        a = sel ? gen_p_grid[k] : gen_e_grid[k];
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return a;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: begin
                if (k == n - 1) return a;
                b = sel ? gen_p_grid[k + 1] : gen_e_grid[k + 1];
                if (b <= a) return a;
                return a + ($urandom % (b - a));
            end
        endcase
    endfunction

    task automatic write_cfg(input logic sel, input logic [ees_pkg::CNT_BITS-1:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = sel;
        i_cfg_data = data;
        #1;
        while (!o_cfg_ready) begin
            @(negedge i_clk);
            #1;
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = ees_pkg::CNT_BITS'($urandom);
    endtask

    // Let every queued request go in and every result come out, then let the block settle.
    task automatic drain();
        wait (pending_reqs.size() == 0 && reqs_taken == reqs_queued &&
              expected_energies.size() == 0);
        repeat (150) @(posedge i_clk);
    endtask

    function automatic int eff_points(input logic [10:0] c);
        return (c == 0) ? 1 : ((c > DEPTH) ? DEPTH : int'(c));
    endfunction

    // One phase: configure, fill what the lookups will read, then sample.
    task automatic run_phase(input logic [10:0] ne, input logic [10:0] np, input int samples);
        int en, pn, i;
        en = eff_points(ne);
        pn = eff_points(np);
        write_cfg(ees_pkg::CFG_ENERGY, ne);
        write_cfg(ees_pkg::CFG_PROB, np);
        if (en <= 16 || e_loaded < en)
            load_table(1'b0, en, (en <= 16) ? $urandom_range(0, 2) : 0);
        if (pn <= 16 || p_loaded < pn)
            load_table(1'b1, pn, (pn <= 16) ? $urandom_range(0, 2) : 0);
        for (i = 0; i < samples; i++) begin
            if ($urandom_range(0, 19) == 0)
                queue_req(OP_IGNORED, 10'($urandom), $urandom, $urandom, $urandom, $urandom);
            queue_req(ees_pkg::OP_SAMPLE, 10'($urandom), $urandom, $urandom,
                      aim_point(1'b0, en), aim_point(1'b1, pn));
        end
        drain();
    endtask

    // Stimulus and end of run.
    initial begin
        int ph;
        logic [10:0] ne, np;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: single-point tables at reset counts, extreme inputs.
        queue_req(ees_pkg::OP_LOAD_E, 10'd0, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
        queue_req(ees_pkg::OP_LOAD_P, 10'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0);
        queue_req(ees_pkg::OP_SAMPLE, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
        queue_req(ees_pkg::OP_SAMPLE, 10'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_IGNORED, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(ees_pkg::OP_LOAD_E, 10'd0, 32'h0001_0000, 32'h0000_0001, 32'h0, 32'h0);
        queue_req(ees_pkg::OP_LOAD_P, 10'd0, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0);
        queue_req(ees_pkg::OP_SAMPLE, 10'h0, 32'h0, 32'h0, 32'h1234_5678, 32'h9ABC_DEF0);
        gen_e_grid[0] = 32'h0001_0000;
        gen_p_grid[0] = 32'h8000_0000;
        e_loaded = 1;
        p_loaded = 1;
        drain();

        // Directed: point count zero, two points, then the full energy table and an
        // over-range count.
        run_phase(11'd0, 11'd0, 6);
        run_phase(11'd2, 11'd2, 10);
        run_phase(11'd1024, 11'd16, 40);
        run_phase(11'd2047, 11'd9, 20);

        // Random phases, mostly small tables.
        for (ph = 0; ph < 14; ph++) begin
            case ($urandom_range(0, 9))
                0: ne = 11'd0;
                1: ne = 11'($urandom_range(17, 2047));
                default: ne = 11'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 9))
                0: np = 11'd1;
                1: np = 11'($urandom_range(17, 64));
                default: np = 11'($urandom_range(1, 16));
            endcase
            run_phase(ne, np, 30);
        end

        $display("Covered %0d requests and %0d results (%0d saturated) over table sizes",
                 reqs_taken, results_seen, sat_seen);
        $display("from one to full depth, including zero and over-range point counts.");
        if (errors == 0 && expected_energies.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #60ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
